// ===== rtl/spr_pkg.sv =====
package spr_pkg;

  localparam int GRID_SIZE_DEF = 8;
  localparam int TRIG_FRAC_DEF = 14;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 3;
  localparam int ANGLE_W   = 9;
  localparam int SCALE_W   = 5;
  localparam int DRAW_W    = 13;
  localparam int COLOR_W   = 16;
  localparam int REM_W     = 7;

  localparam int TURN_STEPS = 360;
  localparam int QUARTER    = 90;
  localparam int OCTANT     = 45;

  localparam logic [COLOR_W-1:0] FILL_WHITE = 16'hFFFF;
  localparam logic signed [DRAW_W-1:0] DRAW_MIN = {1'b1, {(DRAW_W-1){1'b0}}};
  localparam logic signed [DRAW_W-1:0] DRAW_MAX = {1'b0, {(DRAW_W-1){1'b1}}};

  localparam longint unsigned DEG_TO_RAD_Q32 = 64'd74961321;
  localparam longint unsigned ONE_Q32        = 64'h1_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANCHOR_X,
    CFG_ANCHOR_Y,
    CFG_SHIFT_X,
    CFG_SHIFT_Y,
    CFG_TURN,
    CFG_SCALE
  } cfg_reg_t;

  typedef logic signed [31:0] quarter_table_t [QUARTER];

  // Unsigned long division, one quotient bit per step; only the table builders call it.
  function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r    = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Q32.32 Taylor series of sine (odd) or cosine of r degrees, r in 0..45.
  function automatic longint unsigned series_q32(int r, bit odd);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned d;
    longint          sum;
    x    = 64'(r) * DEG_TO_RAD_Q32;
    x2   = (x * x) >> 32;
    term = odd ? x : ONE_Q32;
    sum  = longint'(term);
    for (int n = 1; n <= 7; n++) begin
      d    = odd ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
      term = div_u64((term * x2) >> 32, d);
      if ((n & 1) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    return unsigned'(sum);
  endfunction

  function automatic longint to_frac(longint unsigned q32, int frac_bits);
    return longint'((q32 + (64'd1 << (31 - frac_bits))) >> (32 - frac_bits));
  endfunction

  // Sine of the remainder within a quadrant, 0..89 degrees.
  function automatic quarter_table_t sin_quarter(int frac_bits);
    quarter_table_t t;
    for (int r = 0; r < QUARTER; r++) begin
      if (r <= OCTANT) begin
        t[r] = 32'(to_frac(series_q32(r, 1'b1), frac_bits));
      end else begin
        t[r] = 32'(to_frac(series_q32(QUARTER - r, 1'b0), frac_bits));
      end
    end
    return t;
  endfunction

  // Cosine of the remainder within a quadrant, 0..89 degrees.
  function automatic quarter_table_t cos_quarter(int frac_bits);
    quarter_table_t t;
    for (int r = 0; r < QUARTER; r++) begin
      if (r <= OCTANT) begin
        t[r] = 32'(to_frac(series_q32(r, 1'b0), frac_bits));
      end else begin
        t[r] = 32'(to_frac(series_q32(QUARTER - r, 1'b1), frac_bits));
      end
    end
    return t;
  endfunction

endpackage

// ===== rtl/spr_point_if.sv =====
interface spr_point_if #(
  parameter int COORD_W = 3
) ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] cell_col;
  logic [COORD_W-1:0] cell_row;
  logic               final_point;

  modport source (output valid, output cell_col, output cell_row, output final_point,
                  input ready);
  modport sink (input valid, input cell_col, input cell_row, input final_point,
                output ready);
endinterface

// ===== rtl/spr_block_if.sv =====
interface spr_block_if;
  import spr_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DRAW_W-1:0] draw_x;
  logic signed [DRAW_W-1:0] draw_y;
  logic [SCALE_W-1:0]       block_side;
  logic [COLOR_W-1:0]       fill_color;
  logic                     last_block;

  modport source (output valid, output draw_x, output draw_y, output block_side,
                  output fill_color, output last_block, input ready);
  modport sink (input valid, input draw_x, input draw_y, input block_side,
                input fill_color, input last_block, output ready);
endinterface

// ===== rtl/spr_front.sv =====
module spr_front #(
  parameter int GRID_SIZE      = spr_pkg::GRID_SIZE_DEF,
  parameter int TRIG_FRAC_BITS = spr_pkg::TRIG_FRAC_DEF
) (
  input  logic                                 clk,
  input  logic [1:0]                           en,
  input  logic [$clog2(GRID_SIZE)-1:0]         cell_col,
  input  logic [$clog2(GRID_SIZE)-1:0]         cell_row,
  input  logic [spr_pkg::ANGLE_W-1:0]          turn_degrees,
  output logic signed [$clog2(GRID_SIZE)+1:0]  cx2,
  output logic signed [$clog2(GRID_SIZE)+1:0]  cy2,
  output logic signed [TRIG_FRAC_BITS+1:0]     sn,
  output logic signed [TRIG_FRAC_BITS+1:0]     cs
);
  import spr_pkg::*;

  localparam int COORD_W = $clog2(GRID_SIZE);
  localparam int CX_W    = COORD_W + 2;
  localparam int T_W     = TRIG_FRAC_BITS + 2;

  localparam quarter_table_t SIN_TABLE = sin_quarter(TRIG_FRAC_BITS);
  localparam quarter_table_t COS_TABLE = cos_quarter(TRIG_FRAC_BITS);

  logic [ANGLE_W-1:0]     angle;
  logic [1:0]             quad_next;
  logic [ANGLE_W-1:0]     rem_wide;
  logic [1:0]             quad;
  logic [REM_W-1:0]       rem;
  logic signed [CX_W-1:0] cx2_a;
  logic signed [CX_W-1:0] cy2_a;
  logic signed [T_W-1:0]  sin_r;
  logic signed [T_W-1:0]  cos_r;

  // Stage 1: reduce the angle to quadrant and remainder, move the cell to the centre.
  always_comb begin
    angle = (turn_degrees >= ANGLE_W'(TURN_STEPS)) ? turn_degrees - ANGLE_W'(TURN_STEPS)
                                                   : turn_degrees;
    if (angle >= ANGLE_W'(3 * QUARTER)) begin
      quad_next = 2'd3;
      rem_wide  = angle - ANGLE_W'(3 * QUARTER);
    end else if (angle >= ANGLE_W'(2 * QUARTER)) begin
      quad_next = 2'd2;
      rem_wide  = angle - ANGLE_W'(2 * QUARTER);
    end else if (angle >= ANGLE_W'(QUARTER)) begin
      quad_next = 2'd1;
      rem_wide  = angle - ANGLE_W'(QUARTER);
    end else begin
      quad_next = 2'd0;
      rem_wide  = angle;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      quad  <= quad_next;
      rem   <= rem_wide[REM_W-1:0];
      cx2_a <= signed'({1'b0, cell_col, 1'b0}) - CX_W'(GRID_SIZE - 1);
      cy2_a <= signed'({1'b0, cell_row, 1'b0}) - CX_W'(GRID_SIZE - 1);
    end
  end

  // Stage 2: quarter-wave lookup and quadrant symmetry.
  always_comb begin
    sin_r = SIN_TABLE[rem][T_W-1:0];
    cos_r = COS_TABLE[rem][T_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      cx2 <= cx2_a;
      cy2 <= cy2_a;
      case (quad)
        2'd0: begin
          sn <= sin_r;
          cs <= cos_r;
        end
        2'd1: begin
          sn <= cos_r;
          cs <= -sin_r;
        end
        2'd2: begin
          sn <= -sin_r;
          cs <= -cos_r;
        end
        default: begin
          sn <= -cos_r;
          cs <= sin_r;
        end
      endcase
    end
  end

endmodule

// ===== rtl/spr_rotate.sv =====
module spr_rotate #(
  parameter int GRID_SIZE      = spr_pkg::GRID_SIZE_DEF,
  parameter int TRIG_FRAC_BITS = spr_pkg::TRIG_FRAC_DEF
) (
  input  logic                                                   clk,
  input  logic [1:0]                                             en,
  input  logic signed [$clog2(GRID_SIZE)+1:0]                    cx2,
  input  logic signed [$clog2(GRID_SIZE)+1:0]                    cy2,
  input  logic signed [TRIG_FRAC_BITS+1:0]                       sn,
  input  logic signed [TRIG_FRAC_BITS+1:0]                       cs,
  output logic signed [$clog2(GRID_SIZE)+TRIG_FRAC_BITS+5:0]     rx_p,
  output logic signed [$clog2(GRID_SIZE)+TRIG_FRAC_BITS+5:0]     ry_p
);
  import spr_pkg::*;

  localparam int COORD_W = $clog2(GRID_SIZE);
  localparam int PR_W    = COORD_W + TRIG_FRAC_BITS + 4;
  localparam int P_W     = PR_W + 2;
  localparam logic signed [P_W-1:0] PIV = P_W'((GRID_SIZE - 1) << TRIG_FRAC_BITS);

  logic signed [PR_W-1:0] xc;
  logic signed [PR_W-1:0] ys;
  logic signed [PR_W-1:0] xs;
  logic signed [PR_W-1:0] yc;

  // Stage 3: the four products, in units of half a trig LSB.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      xc <= PR_W'(cx2) * PR_W'(cs);
      ys <= PR_W'(cy2) * PR_W'(sn);
      xs <= PR_W'(cx2) * PR_W'(sn);
      yc <= PR_W'(cy2) * PR_W'(cs);
    end
  end

  // Stage 4: combine and move back from the grid centre.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      rx_p <= P_W'(xc) - P_W'(ys) + PIV;
      ry_p <= P_W'(xs) + P_W'(yc) + PIV;
    end
  end

endmodule

// ===== rtl/spr_place.sv =====
module spr_place #(
  parameter int GRID_SIZE      = spr_pkg::GRID_SIZE_DEF,
  parameter int TRIG_FRAC_BITS = spr_pkg::TRIG_FRAC_DEF
) (
  input  logic                                               clk,
  input  logic [2:0]                                         en,
  input  logic signed [$clog2(GRID_SIZE)+TRIG_FRAC_BITS+5:0] rx_p,
  input  logic signed [$clog2(GRID_SIZE)+TRIG_FRAC_BITS+5:0] ry_p,
  input  logic [spr_pkg::SCALE_W-1:0]                        block_scale,
  input  logic signed [spr_pkg::CFG_W-1:0]                   anchor_x,
  input  logic signed [spr_pkg::CFG_W-1:0]                   anchor_y,
  input  logic signed [spr_pkg::CFG_W-1:0]                   shift_x,
  input  logic signed [spr_pkg::CFG_W-1:0]                   shift_y,
  output logic signed [spr_pkg::DRAW_W-1:0]                  draw_x,
  output logic signed [spr_pkg::DRAW_W-1:0]                  draw_y
);
  import spr_pkg::*;

  localparam int COORD_W = $clog2(GRID_SIZE);
  localparam int P_W     = COORD_W + TRIG_FRAC_BITS + 6;
  localparam int S_W     = P_W + SCALE_W + 1;
  localparam int U_W     = S_W + 1;
  localparam int SH      = TRIG_FRAC_BITS + 1;
  localparam int PX_W    = U_W - SH;
  localparam int SUM_W   = ((PX_W > CFG_W) ? PX_W : CFG_W) + 2;
  localparam logic signed [U_W-1:0] HALF = U_W'(1) <<< TRIG_FRAC_BITS;
  localparam logic signed [U_W-1:0] MASK = (U_W'(1) <<< SH) - U_W'(1);

  logic signed [S_W-1:0]   sx;
  logic signed [S_W-1:0]   sy;
  logic signed [U_W-1:0]   tx;
  logic signed [U_W-1:0]   ty;
  logic signed [U_W-1:0]   zx;
  logic signed [U_W-1:0]   zy;
  logic signed [PX_W-1:0]  px;
  logic signed [PX_W-1:0]  py;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;

  function automatic logic signed [DRAW_W-1:0] clamp(logic signed [SUM_W-1:0] v);
    if (v < SUM_W'(DRAW_MIN)) begin
      return DRAW_MIN;
    end else if (v > SUM_W'(DRAW_MAX)) begin
      return DRAW_MAX;
    end
    return v[DRAW_W-1:0];
  endfunction

  // Stage 5: scale by the block size.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      sx <= S_W'(rx_p) * S_W'(signed'({1'b0, block_scale}));
      sy <= S_W'(ry_p) * S_W'(signed'({1'b0, block_scale}));
    end
  end

  // Stage 6: add one half, then truncate toward zero. A negative value is biased
  // up by all ones below the cut so that the arithmetic shift rounds toward zero.
  always_comb begin
    tx = U_W'(sx) + HALF;
    ty = U_W'(sy) + HALF;
    zx = tx + (tx[U_W-1] ? MASK : U_W'(0));
    zy = ty + (ty[U_W-1] ? MASK : U_W'(0));
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      px <= PX_W'(zx >>> SH);
      py <= PX_W'(zy >>> SH);
    end
  end

  // Stage 7: screen offsets and saturation.
  always_comb begin
    sum_x = SUM_W'(px) + SUM_W'(anchor_x) + SUM_W'(shift_x);
    sum_y = SUM_W'(py) + SUM_W'(anchor_y) + SUM_W'(shift_y);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      draw_x <= clamp(sum_x);
      draw_y <= clamp(sum_y);
    end
  end

endmodule

// ===== rtl/sprite_point_rotate_scale.sv =====
// Rotates each lit cell of a sprite grid about the grid centre by turn_degrees, scales
// it by block_scale with round-half-up truncated toward zero, adds anchor and shift, and
// emits one white square of side block_scale at the saturated 13-bit screen position.
// The block is a seven-stage pipeline: one item is taken every clock cycle unless an
// output stall reaches the input; each result leaves when the output side is ready.
// Each stage holds its own valid bit, so a stall at the output fills empty stages
// before the input side stops. Sine and cosine come from two 90-entry quarter-wave
// constant tables built at elaboration, indexed by the quadrant remainder of the
// angle reduced modulo 360. The user writes registers via cfg_write/cfg_index/cfg_data
// only while no item is in flight, unchecked by the block; indexes above the last are ignored.
module sprite_point_rotate_scale #(
  parameter int GRID_SIZE      = spr_pkg::GRID_SIZE_DEF,
  parameter int TRIG_FRAC_BITS = spr_pkg::TRIG_FRAC_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [spr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spr_pkg::CFG_W-1:0]     cfg_data,
  spr_point_if.sink                     points,
  spr_block_if.source                   blocks
);
  import spr_pkg::*;

  localparam int NSTAGE  = 7;
  localparam int COORD_W = $clog2(GRID_SIZE);
  localparam int CX_W    = COORD_W + 2;
  localparam int T_W     = TRIG_FRAC_BITS + 2;
  localparam int P_W     = COORD_W + TRIG_FRAC_BITS + 6;

  logic signed [CFG_W-1:0] anchor_x;
  logic signed [CFG_W-1:0] anchor_y;
  logic signed [CFG_W-1:0] shift_x;
  logic signed [CFG_W-1:0] shift_y;
  logic [ANGLE_W-1:0]      turn_degrees;
  logic [SCALE_W-1:0]      block_scale;

  logic [NSTAGE-1:0] v;
  logic [NSTAGE-1:0] last_pipe;
  logic [NSTAGE:0]   adv;

  logic signed [CX_W-1:0] cx2;
  logic signed [CX_W-1:0] cy2;
  logic signed [T_W-1:0]  sn;
  logic signed [T_W-1:0]  cs;
  logic signed [P_W-1:0]  rx_p;
  logic signed [P_W-1:0]  ry_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_x     <= '0;
      anchor_y     <= '0;
      shift_x      <= '0;
      shift_y      <= '0;
      turn_degrees <= '0;
      block_scale  <= SCALE_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ANCHOR_X: anchor_x     <= cfg_data;
        CFG_ANCHOR_Y: anchor_y     <= cfg_data;
        CFG_SHIFT_X:  shift_x      <= cfg_data;
        CFG_SHIFT_Y:  shift_y      <= cfg_data;
        CFG_TURN:     turn_degrees <= cfg_data[ANGLE_W-1:0];
        CFG_SCALE:    block_scale  <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    adv[NSTAGE] = blocks.ready;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= points.valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      last_pipe[0] <= points.final_point;
    end
    for (int k = 1; k < NSTAGE; k++) begin
      if (adv[k]) begin
        last_pipe[k] <= last_pipe[k-1];
      end
    end
  end

  spr_front #(
    .GRID_SIZE      (GRID_SIZE),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .en           (adv[1:0]),
    .cell_col     (points.cell_col),
    .cell_row     (points.cell_row),
    .turn_degrees (turn_degrees),
    .cx2          (cx2),
    .cy2          (cy2),
    .sn           (sn),
    .cs           (cs)
  );

  spr_rotate #(
    .GRID_SIZE      (GRID_SIZE),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_rotate (
    .clk  (clk),
    .en   (adv[3:2]),
    .cx2  (cx2),
    .cy2  (cy2),
    .sn   (sn),
    .cs   (cs),
    .rx_p (rx_p),
    .ry_p (ry_p)
  );

  spr_place #(
    .GRID_SIZE      (GRID_SIZE),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_place (
    .clk         (clk),
    .en          (adv[6:4]),
    .rx_p        (rx_p),
    .ry_p        (ry_p),
    .block_scale (block_scale),
    .anchor_x    (anchor_x),
    .anchor_y    (anchor_y),
    .shift_x     (shift_x),
    .shift_y     (shift_y),
    .draw_x      (blocks.draw_x),
    .draw_y      (blocks.draw_y)
  );

  assign points.ready      = adv[0];
  assign blocks.valid      = v[NSTAGE-1];
  assign blocks.block_side = block_scale;
  assign blocks.fill_color = FILL_WHITE;
  assign blocks.last_block = last_pipe[NSTAGE-1];

  a_reset_empties: assert property (@(posedge clk) rst |=> v == '0)
    else $error("pipeline holds an item after reset");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !v[NSTAGE-1] |-> points.ready)
    else $error("input refused while the output stage is empty");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    points.valid && points.ready |=> v[0])
    else $error("accepted item did not enter the first stage");

  a_bubble_fills: assert property (@(posedge clk) disable iff (rst)
    v[NSTAGE-2] && !v[NSTAGE-1] |=> v[NSTAGE-1])
    else $error("item did not move into an empty output stage");

  a_taken_no_repeat: assert property (@(posedge clk) disable iff (rst)
    blocks.valid && blocks.ready && !v[NSTAGE-2] |=> !blocks.valid)
    else $error("result repeated after it was taken");

endmodule
